@@ src/hrss_pkg.sv @@
// ----------------------------------------------------------------------------
// hrss_pkg: shared types and constants of the halving ring step schedule
// Holds the phase and register codes, the command record that travels from
// the front end through the queue to the back end, and the step count helper.
// ----------------------------------------------------------------------------
package hrss_pkg;

  // Largest ring the schedule supports
  localparam logic [7:0] MAX_RANKS = 8'd128;

  // Phase codes of the op field
  localparam logic OP_REDUCE_SCATTER = 1'b0;
  localparam logic OP_ALL_GATHER     = 1'b1;

  // Configuration register indexes
  localparam logic CFG_RANK_COUNT = 1'b0;
  localparam logic CFG_MY_RANK    = 1'b1;

  // One classified request, ready for the back end to expand into slices
  typedef struct packed {
    logic       bad;         // rejected request, one flagged result
    logic [6:0] to_rank;
    logic [6:0] from_rank;
    logic [6:0] tx_slice;    // first tx slice of the run
    logic [6:0] rx_slice;    // first rx slice of the run
    logic [6:0] stride_mod;  // slice stride reduced modulo the ring size
    logic [7:0] rank_count;
    logic [6:0] count;       // results in the run, 1..64
    logic [2:0] step_count;
  } cmd_t;

  // Number of bits of r-1, saturated at 7 (zero for r of 0 or 1)
  function automatic logic [2:0] steps_of(input logic [7:0] r);
    logic [7:0] t;
    logic [3:0] n;
    t = (r == 8'd0) ? 8'd0 : r - 8'd1;
    n = 4'd0;
    for (int b = 0; b < 8; b++) begin
      if (t[b]) begin
        n = 4'(b + 1);
      end
    end
    steps_of = (n > 4'd7) ? 3'd7 : n[2:0];
  endfunction

endpackage

@@ src/hrss_front.sv @@
// ----------------------------------------------------------------------------
// hrss_front: request classifier
// Checks a request against the ring configuration and works out peers,
// first slices, the reduced stride and the length of the run.
// ----------------------------------------------------------------------------
module hrss_front (
  input  logic                op_i,
  input  logic [2:0]          step_i,
  input  logic [7:0]          rank_count_i,
  input  logic [6:0]          my_rank_i,
  output hrss_pkg::cmd_t      cmd_o
);

  logic [2:0] steps;
  logic       bad;
  logic [2:0] shamt;
  logic [7:0] hop;
  logic [8:0] me_sub;
  logic [8:0] me_add;
  logic [8:0] me_dn;
  logic [8:0] me_up;
  logic [8:0] stride;
  logic [8:0] stride_mod;
  logic [8:0] span;
  logic [8:0] count;

  // Validate the request
  assign steps = hrss_pkg::steps_of(rank_count_i);
  assign bad   = (rank_count_i < 8'd2) || (rank_count_i > hrss_pkg::MAX_RANKS) ||
                 ({1'b0, my_rank_i} >= rank_count_i) || (step_i >= steps);

  // Pick the distance exponent of the phase
  always_comb begin
    unique case (op_i)
      hrss_pkg::OP_REDUCE_SCATTER: shamt = step_i;
      hrss_pkg::OP_ALL_GATHER:     shamt = steps - 3'd1 - step_i;
      default:                     shamt = step_i;
    endcase
  end

  // Neighbors at distance d on both sides of the ring
  assign hop    = 8'd1 << shamt;
  assign me_sub = {2'b00, my_rank_i} - {1'b0, hop};
  assign me_dn  = me_sub[8] ? me_sub + {1'b0, rank_count_i} : me_sub;
  assign me_add = {2'b00, my_rank_i} + {1'b0, hop};
  assign me_up  = (me_add >= {1'b0, rank_count_i}) ? me_add - {1'b0, rank_count_i}
                                                   : me_add;

  // Stride of 2d, reduced once since it stays below twice the ring size
  assign stride     = {hop, 1'b0};
  assign stride_mod = (stride >= {1'b0, rank_count_i}) ? stride - {1'b0, rank_count_i}
                                                       : stride;

  // Run length (R-1+d)/2d as a shift
  assign span  = {1'b0, rank_count_i} - 9'd1 + {1'b0, hop};
  assign count = span >> ({1'b0, shamt} + 4'd1);

  // Assemble the command
  always_comb begin
    cmd_o            = '0;
    cmd_o.bad        = bad;
    cmd_o.step_count = steps;
    cmd_o.rank_count = rank_count_i;
    cmd_o.stride_mod = stride_mod[6:0];
    if (bad) begin
      cmd_o.count = 7'd1;
    end else begin
      cmd_o.count = (count > 9'd64) ? 7'd64 : count[6:0];
      unique case (op_i)
        hrss_pkg::OP_REDUCE_SCATTER: begin
          cmd_o.to_rank   = me_dn[6:0];
          cmd_o.from_rank = me_up[6:0];
          cmd_o.tx_slice  = me_dn[6:0];
          cmd_o.rx_slice  = my_rank_i;
        end
        hrss_pkg::OP_ALL_GATHER: begin
          cmd_o.to_rank   = me_up[6:0];
          cmd_o.from_rank = me_dn[6:0];
          cmd_o.tx_slice  = my_rank_i;
          cmd_o.rx_slice  = me_dn[6:0];
        end
        default: begin
          cmd_o.to_rank   = me_dn[6:0];
          cmd_o.from_rank = me_up[6:0];
          cmd_o.tx_slice  = me_dn[6:0];
          cmd_o.rx_slice  = my_rank_i;
        end
      endcase
    end
  end

endmodule

@@ src/hrss_queue.sv @@
// ----------------------------------------------------------------------------
// hrss_queue: command queue between front and back end
// Small register FIFO of classified commands.
// ----------------------------------------------------------------------------
module hrss_queue #(
  parameter int DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hrss_pkg::cmd_t push_cmd_i,
  input  logic           pop_i,
  output hrss_pkg::cmd_t pop_cmd_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  hrss_pkg::cmd_t     mem_q [DEPTH];
  logic [PW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]      cnt_q, cnt_d;

  assign full_o    = (cnt_q == FULL_CNT);
  assign empty_o   = (cnt_q == '0);
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ src/hrss_back.sv @@
// ----------------------------------------------------------------------------
// hrss_back: slice sequencer
// Expands one command into its run of results, one slice per unstalled cycle,
// straight from the output registers; loads the next command as the last one leaves.
// ----------------------------------------------------------------------------
module hrss_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  hrss_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [6:0]     to_rank_o,
  output logic [6:0]     from_rank_o,
  output logic [6:0]     tx_slice_o,
  output logic [6:0]     rx_slice_o,
  output logic [5:0]     slice_pos_o,
  output logic [2:0]     step_count_o,
  output logic           bad_request_o,
  output logic           last_o
);

  logic           busy_q, busy_d;
  hrss_pkg::cmd_t cur_q, cur_d;
  logic [5:0]     pos_q, pos_d;
  logic           last;
  logic           accept;
  logic           done;
  logic           load;

  // Step a slice index down by the stride, wrapping around the ring
  function automatic logic [6:0] ring_down(input logic [6:0] v, input logic [6:0] s,
                                           input logic [7:0] r);
    logic [7:0] d;
    d = {1'b0, v} - {1'b0, s};
    if (d[7]) begin
      d = d + r;
    end
    ring_down = d[6:0];
  endfunction

  assign last   = (({1'b0, pos_q} + 7'd1) == cur_q.count);
  assign accept = busy_q && !out_stall_i;
  assign done   = accept && last;
  assign load   = cmd_valid_i && (!busy_q || done);

  // Load a new run or advance the current one
  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    pos_d  = pos_q;
    if (load) begin
      busy_d = 1'b1;
      cur_d  = cmd_i;
      pos_d  = '0;
    end else if (done) begin
      busy_d = 1'b0;
    end else if (accept) begin
      cur_d.tx_slice = ring_down(cur_q.tx_slice, cur_q.stride_mod, cur_q.rank_count);
      cur_d.rx_slice = ring_down(cur_q.rx_slice, cur_q.stride_mod, cur_q.rank_count);
      pos_d          = pos_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    pos_q <= pos_d;
  end

  // Drive the result from the run registers
  assign cmd_pop_o     = load;
  assign out_valid_o   = busy_q;
  assign to_rank_o     = cur_q.to_rank;
  assign from_rank_o   = cur_q.from_rank;
  assign tx_slice_o    = cur_q.tx_slice;
  assign rx_slice_o    = cur_q.rx_slice;
  assign slice_pos_o   = pos_q;
  assign step_count_o  = cur_q.step_count;
  assign bad_request_o = cur_q.bad;
  assign last_o        = last;

endmodule

@@ src/halving_ring_step_schedule_core.sv @@
// ----------------------------------------------------------------------------
// halving_ring_step_schedule_core: distance-halving ring all-reduce schedule
// Turns a (phase, step) request into the run of slice transfers of that step.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o | op_i, step_i
//   out     | output    | out_valid_o/out_stall_i | to_rank_o .. last_o
//   cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// A request is classified in the cycle it is accepted and queued; it is taken
// while the queue has room. The back end emits one result per cycle while
// out_stall_i is low, so a request occupies it for its run length of (R-1+d)/2d
// results (1 to 64; one for a rejected request), with no gap between runs. Output
// stall holds the current result; input stall rises only when the queue is full.
// Reset sets rank_count to 2 and my_rank to 0 and empties queue and sequencer.
// ----------------------------------------------------------------------------
module halving_ring_step_schedule_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [2:0] step_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [6:0] to_rank_o,
  output logic [6:0] from_rank_o,
  output logic [6:0] tx_slice_o,
  output logic [6:0] rx_slice_o,
  output logic [5:0] slice_pos_o,
  output logic [2:0] step_count_o,
  output logic       bad_request_o,
  output logic       last_o
);

  logic [7:0]     rank_count_q;
  logic [6:0]     my_rank_q;
  hrss_pkg::cmd_t front_cmd;
  hrss_pkg::cmd_t queue_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  logic           push;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rank_count_q <= 8'd2;
      my_rank_q    <= 7'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hrss_pkg::CFG_RANK_COUNT: rank_count_q <= cfg_data_i;
        hrss_pkg::CFG_MY_RANK:    my_rank_q    <= cfg_data_i[6:0];
        default:                  rank_count_q <= rank_count_q;
      endcase
    end
  end

  // Classify the incoming request
  hrss_front u_front (
    .op_i         (op_i),
    .step_i       (step_i),
    .rank_count_i (rank_count_q),
    .my_rank_i    (my_rank_q),
    .cmd_o        (front_cmd)
  );

  assign push       = in_valid_i && !q_full;
  assign in_stall_o = q_full;

  // Decouple front and back
  hrss_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (front_cmd),
    .pop_i      (q_pop),
    .pop_cmd_o  (queue_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // Expand commands into slice results
  hrss_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!q_empty),
    .cmd_i         (queue_cmd),
    .cmd_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .to_rank_o     (to_rank_o),
    .from_rank_o   (from_rank_o),
    .tx_slice_o    (tx_slice_o),
    .rx_slice_o    (rx_slice_o),
    .slice_pos_o   (slice_pos_o),
    .step_count_o  (step_count_o),
    .bad_request_o (bad_request_o),
    .last_o        (last_o)
  );

  // A rejected request is a single result at position zero
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_request_o) |-> (last_o && (slice_pos_o == 6'd0)))
    else $error("rejected request not a single result");

  // Within a run the position counts up by one per taken result
  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=>
      (out_valid_o && (slice_pos_o == $past(slice_pos_o) + 6'd1)))
    else $error("slice position did not advance");

  // Slices of an accepted request stay inside the ring
  a_slice_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !bad_request_o) |->
      (({1'b0, tx_slice_o} < rank_count_q) && ({1'b0, rx_slice_o} < rank_count_q)))
    else $error("slice index outside the ring");

  // Never pop a command while the queue is empty
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_empty |-> !q_pop)
    else $error("pop from empty queue");

endmodule
